// File: rtl/twbs_pkg.sv
// ----------------------------------------------------------------------------
// twbs_pkg: shared types and phase decoding for the two-wire byte sender
// Holds the phase numbering of one byte frame and the function that maps a
// phase number and the byte to the pin levels of that phase.
// ----------------------------------------------------------------------------
package twbs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 5;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [PhaseW-1:0] phase_t;

  // Phase numbering of a full frame. An item without start begins at
  // PhBit0, and an item without stop ends at PhAck2.
  localparam phase_t PhStart0 = 5'd0;
  localparam phase_t PhStart1 = 5'd1;
  localparam phase_t PhBit0   = 5'd2;
  localparam phase_t PhBitEnd = 5'd17;
  localparam phase_t PhAck0   = 5'd18;
  localparam phase_t PhAck1   = 5'd19;
  localparam phase_t PhAck2   = 5'd20;
  localparam phase_t PhStop0  = 5'd21;
  localparam phase_t PhStop1  = 5'd22;
  localparam phase_t PhStop2  = 5'd23;
  localparam phase_t PhStop3  = 5'd24;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic data_drive;
    logic ack_sample;
  } pins_t;

  // Pin levels of one phase. A released data pin reads as high.
  function automatic pins_t phase_pins(phase_t ph, byte_t data);
    pins_t  p;
    phase_t j;
    p = '{clock_level: 1'b0, data_level: 1'b1, data_drive: 1'b0, ack_sample: 1'b0};
    j = ph - PhBit0;
    if (ph >= PhBit0 && ph <= PhBitEnd) begin
      p.clock_level = j[0];
      p.data_level  = data[j[3:1]];
      p.data_drive  = 1'b1;
    end else begin
      unique case (ph)
        PhStart0: begin
          p.clock_level = 1'b1;
          p.data_drive  = 1'b1;
        end
        PhStart1: begin
          p.clock_level = 1'b1;
          p.data_level  = 1'b0;
          p.data_drive  = 1'b1;
        end
        PhAck0:  p.ack_sample  = 1'b1;
        PhAck1:  p.clock_level = 1'b1;
        PhAck2:  p.clock_level = 1'b0;
        PhStop0: p.clock_level = 1'b0;
        PhStop1: begin
          p.data_level = 1'b0;
          p.data_drive = 1'b1;
        end
        PhStop2: begin
          p.clock_level = 1'b1;
          p.data_level  = 1'b0;
          p.data_drive  = 1'b1;
        end
        PhStop3: begin
          p.clock_level = 1'b1;
          p.data_drive  = 1'b1;
        end
        default: p = '{clock_level: 1'b0, data_level: 1'b1, data_drive: 1'b0,
                       ack_sample: 1'b0};
      endcase
    end
    return p;
  endfunction

endpackage

// File: rtl/two_wire_byte_sender_core.sv
// ----------------------------------------------------------------------------
// two_wire_byte_sender_core: byte to pin-phase sequencer for a two-wire bus
// Each input request carries one byte with start and stop flags; the block
// emits one output request per pin phase, least significant bit first.
// ----------------------------------------------------------------------------
// Usage: the input channel takes a byte with its first/last flags. The output
// channel returns one pin phase per request: clock level, data level, data
// drive enable, an acknowledge sample marker and a marker on the final phase
// of the byte. A byte gives 19 phases, plus 2 when it opens with a start
// condition and plus 4 when it closes with a stop condition (at most 25).
// An accepted byte enters the byte holding register, and each phase then
// passes the output register. One phase leaves per cycle unless the receiver
// stalls, as the phase counter walks the held byte. The next byte is accepted
// in the same cycle as the final phase of the current byte is loaded into
// the output register, so phases of consecutive bytes follow without a gap.
// Reset empties both the byte holding register and the output register.
// When the receiver stalls, the output register holds its phase, the phase
// counter stops and the input waits until the final phase has been loaded.
// ----------------------------------------------------------------------------
module two_wire_byte_sender_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  twbs_pkg::byte_t      data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 clock_level_o,
  output logic                 data_level_o,
  output logic                 data_drive_o,
  output logic                 ack_sample_o,
  output logic                 phase_last_o
);
  import twbs_pkg::*;

  // Byte holding register and its phase counter.
  logic   busy_q, busy_d;
  byte_t  byte_q;
  logic   last_q;
  phase_t phase_q, phase_d;

  // Output register.
  logic   out_valid_q, out_valid_d;
  pins_t  pins_q;
  logic   phase_last_q;

  logic   out_load;
  logic   final_phase;
  logic   in_accept;
  pins_t  pins_next;

  // The output register can take a new phase when it is empty or being read.
  assign out_load    = !out_valid_q || out_ready_i;
  assign final_phase = last_q ? (phase_q == PhStop3) : (phase_q == PhAck2);
  assign pins_next   = phase_pins(phase_q, byte_q);

  // A new byte may enter when none is held or the held one is finishing.
  assign in_ready_o = !busy_q || (out_load && final_phase);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        phase_d = phase_q + 5'd1;
        if (final_phase) begin
          busy_d = 1'b0;
        end
      end
    end
    if (in_accept) begin
      busy_d  = 1'b1;
      phase_d = first_byte_i ? PhStart0 : PhBit0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PhStart0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (out_load && busy_q) begin
      pins_q       <= pins_next;
      phase_last_q <= final_phase;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clock_level_o = pins_q.clock_level;
  assign data_level_o  = pins_q.data_level;
  assign data_drive_o  = pins_q.data_drive;
  assign ack_sample_o  = pins_q.ack_sample;
  assign phase_last_o  = phase_last_q;

endmodule
